FILE: design/sldf_pkg.sv
// Package for the sync/length frame deframer.
// Holds the result kind codes, field widths and the result record.
// Used by sldf_parser, sync_length_frame_deframer and sldf_checker.
package sldf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned TypeW  = 16;
  localparam int unsigned LenW   = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned OutW   = ByteW + ByteW + TypeW + LenW;

  localparam logic [ByteW-1:0] SyncReset = 8'd126;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [LenW-1:0]  payload_length;
    logic [TypeW-1:0] message_type;
    logic [ByteW-1:0] sender;
    logic [ByteW-1:0] payload_byte;
    kind_t            kind;
  } result_t;

endpackage

FILE: design/sync_length_frame_deframer.sv
// Top level of the sync/length frame deframer: ports, sync register, result register.
// Depends on sldf_pkg and sldf_parser.
//
// Channel  | Direction | Signals                    | Contents
// s        | in        | s_tvalid s_tready s_tdata  | rx_byte [7:0]
// m        | out       | m_tvalid m_tready m_tdata  | payload_byte, sender, message_type,
//          |           | m_tuser                    |   payload_length; tuser: kind
// cfg      | in        | cfg_valid cfg_ready cfg_data | sync_value [7:0]
//
// One byte per cycle unless stalled: a byte is decoded in its accept cycle, any
// result enters the output register at that edge, showing on m_tvalid the next cycle.
// The output register stalls input only while it is full and not taken.
// Reset returns the parser to hunting and sets sync_value to 126.
module sync_length_frame_deframer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [sldf_pkg::ByteW-1:0] s_tdata,  // [7:0] rx_byte
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [7:0] payload_byte, [15:8] sender, [31:16] message_type, [63:32] payload_length
  output logic [sldf_pkg::OutW-1:0] m_tdata,
  output logic [sldf_pkg::KindW-1:0] m_tuser, // [1:0] kind
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sldf_pkg::ByteW-1:0] cfg_data  // [7:0] sync_value
);
  import sldf_pkg::*;

  logic [ByteW-1:0] sync_value;
  logic             step;
  logic             res_valid;
  result_t          res;
  result_t          out_reg;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign step      = s_tvalid && s_tready;

  // Hold the sync byte value
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SyncReset;
    end else if (cfg_valid && cfg_ready) begin
      sync_value <= cfg_data;
    end
  end

  sldf_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (s_tdata),
    .sync_value (sync_value),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_reg <= res;
    end
  end

  assign m_tdata = {out_reg.payload_length, out_reg.message_type,
                    out_reg.sender, out_reg.payload_byte};
  assign m_tuser = out_reg.kind;

endmodule

FILE: design/sldf_parser.sv
// Frame parser: header, payload and checksum phase tracking.
// Produces at most one result per accepted byte, combinationally.
// Depends on sldf_pkg.
module sldf_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [sldf_pkg::ByteW-1:0] rx_byte,
  input  logic [sldf_pkg::ByteW-1:0] sync_value,
  output logic                       res_valid,
  output sldf_pkg::result_t          res
);
  import sldf_pkg::*;

  typedef enum logic [3:0] {
    PH_SYNC0  = 4'd0,
    PH_SYNC1  = 4'd1,
    PH_SENDER = 4'd2,
    PH_SEQ    = 4'd3,
    PH_VER    = 4'd4,
    PH_TYPE0  = 4'd5,
    PH_TYPE1  = 4'd6,
    PH_LEN0   = 4'd7,
    PH_LEN1   = 4'd8,
    PH_LEN2   = 4'd9,
    PH_LEN3   = 4'd10,
    PH_DATA   = 4'd11,
    PH_CHK0   = 4'd12,
    PH_CHK1   = 4'd13
  } phase_t;

  phase_t           phase, phase_next;
  logic [ByteW-1:0] frame_sender, frame_sender_next;
  logic [TypeW-1:0] frame_type, frame_type_next;
  logic [LenW-1:0]  frame_length, frame_length_next;
  logic [LenW-1:0]  bytes_received, bytes_received_next;
  logic [ByteW-1:0] check_low, check_low_next;
  logic [LenW-1:0]  count_inc;
  logic [LenW-1:0]  full_length;

  assign count_inc   = bytes_received + LenW'(1);
  assign full_length = {rx_byte, frame_length[23:0]};

  // Decode one byte: next phase, header capture, optional result
  always_comb begin
    phase_next          = phase;
    frame_sender_next   = frame_sender;
    frame_type_next     = frame_type;
    frame_length_next   = frame_length;
    bytes_received_next = bytes_received;
    check_low_next      = check_low;
    res_valid           = 1'b0;
    res.kind            = KIND_PAYLOAD;
    res.payload_byte    = '0;
    res.sender          = frame_sender;
    res.message_type    = frame_type;
    res.payload_length  = frame_length;
    unique case (phase)
      PH_SYNC0: phase_next = (rx_byte == sync_value) ? PH_SYNC1 : PH_SYNC0;
      PH_SYNC1: phase_next = (rx_byte == sync_value) ? PH_SENDER : PH_SYNC0;
      PH_SENDER: begin
        frame_sender_next = rx_byte;
        phase_next        = PH_SEQ;
      end
      PH_SEQ: phase_next = PH_VER;
      PH_VER: phase_next = PH_TYPE0;
      PH_TYPE0: begin
        frame_type_next = {{(TypeW-ByteW){1'b0}}, rx_byte};
        phase_next      = PH_TYPE1;
      end
      PH_TYPE1: begin
        frame_type_next     = {rx_byte, frame_type[7:0]};
        frame_length_next   = '0;
        bytes_received_next = '0;
        check_low_next      = '0;
        phase_next          = PH_LEN0;
      end
      PH_LEN0: begin
        frame_length_next = {{(LenW-ByteW){1'b0}}, rx_byte};
        phase_next        = PH_LEN1;
      end
      PH_LEN1: begin
        frame_length_next = {frame_length[31:16], rx_byte, frame_length[7:0]};
        phase_next        = PH_LEN2;
      end
      PH_LEN2: begin
        frame_length_next = {frame_length[31:24], rx_byte, frame_length[15:0]};
        phase_next        = PH_LEN3;
      end
      PH_LEN3: begin
        frame_length_next = full_length;
        // empty frame goes straight to the checksum
        phase_next        = (full_length == '0) ? PH_CHK0 : PH_DATA;
      end
      PH_DATA: begin
        bytes_received_next = count_inc;
        if (count_inc >= frame_length) begin
          phase_next = PH_CHK0;
        end
        res_valid        = 1'b1;
        res.payload_byte = rx_byte;
      end
      PH_CHK0: begin
        check_low_next = rx_byte;
        phase_next     = PH_CHK1;
      end
      PH_CHK1: begin
        phase_next = PH_SYNC0;
        res_valid  = 1'b1;
        res.kind   = ({rx_byte, check_low} == '0) ? KIND_ACCEPT : KIND_REJECT;
      end
      default: phase_next = PH_SYNC0;
    endcase
  end

  // Advance state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC0;
      frame_sender   <= '0;
      frame_type     <= '0;
      frame_length   <= '0;
      bytes_received <= '0;
      check_low      <= '0;
    end else if (step) begin
      phase          <= phase_next;
      frame_sender   <= frame_sender_next;
      frame_type     <= frame_type_next;
      frame_length   <= frame_length_next;
      bytes_received <= bytes_received_next;
      check_low      <= check_low_next;
    end
  end

endmodule

FILE: design/sldf_checker.sv
// Port-level checker for the frame deframer, bound to the top level.
// Depends on sldf_pkg and sync_length_frame_deframer.
module sldf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [sldf_pkg::OutW-1:0]  m_tdata,
  input logic [sldf_pkg::KindW-1:0] m_tuser
);
  import sldf_pkg::*;

  // Output holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Input is back-pressured only by a stalled result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready not tied to output stall");

  // Frame-end results carry a zero payload byte and a legal kind
  a_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_PAYLOAD |->
      m_tdata[7:0] == '0 && (m_tuser == KIND_ACCEPT || m_tuser == KIND_REJECT))
    else $error("bad frame-end result");

endmodule

bind sync_length_frame_deframer sldf_checker u_sldf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: tb/tb_top.sv
// Self-checking testbench for sync_length_frame_deframer: a byte-stream model predicts
// each payload byte and frame-end result, and a checker compares them with the output.
// Depends on sldf_pkg and the sync_length_frame_deframer RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sldf_pkg::*;

  localparam int StallLimit = 300;

  // Receive progress through one frame
  typedef enum logic [3:0] {
    PH_SYNC0, PH_SYNC1, PH_SENDER, PH_SEQ, PH_VER, PH_TYPE_LO, PH_TYPE_HI,
    PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3, PH_PAYLOAD, PH_CHECK_LO, PH_CHECK_HI
  } rx_phase_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic [ByteW-1:0]    s_tdata   = '0;
  logic                m_tready  = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [ByteW-1:0]    cfg_data  = '0;
  logic                s_tready;
  logic                m_tvalid;
  logic [OutW-1:0]     m_tdata;
  logic [KindW-1:0]    m_tuser;
  logic                cfg_ready;

  // Deframer model state
  logic [7:0]  sync_shadow   = SyncReset;
  rx_phase_t   rx_phase      = PH_SYNC0;
  logic [7:0]  hdr_sender    = '0;
  logic [15:0] hdr_type      = '0;
  logic [31:0] hdr_length    = '0;
  logic [31:0] payload_count = '0;
  logic [7:0]  check_lo_byte = '0;
  result_t     pending_results[$];
  result_t     want_result;

  logic idle_on        = 1'b1;
  int   mismatch_count = 0;
  int   results_checked = 0;
  int   bytes_sent     = 0;
  int   frames_sent    = 0;
  int   sync_writes    = 0;
  int   stall_cycles   = 0;

  sync_length_frame_deframer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random while idling is enabled
  always @(negedge clk) begin
    m_tready = !idle_on || ($urandom_range(0, 99) >= 15);
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_result(input kind_t k, input logic [7:0] pbyte);
    result_t r;
    r.kind           = k;
    r.payload_byte   = pbyte;
    r.sender         = hdr_sender;
    r.message_type   = hdr_type;
    r.payload_length = hdr_length;
    pending_results.push_back(r);
  endtask

  // Advance the deframer model by one accepted byte
  task automatic deframe_byte(input logic [7:0] b);
    case (rx_phase)
      PH_SYNC0, PH_SYNC1: begin
        rx_phase = (b == sync_shadow) ? rx_phase_t'(rx_phase + 1) : PH_SYNC0;
      end
      PH_SENDER: begin
        hdr_sender = b;
        rx_phase   = PH_SEQ;
      end
      PH_SEQ:     rx_phase = PH_VER;
      PH_VER:     rx_phase = PH_TYPE_LO;
      PH_TYPE_LO: begin
        hdr_type = {8'h00, b};
        rx_phase = PH_TYPE_HI;
      end
      PH_TYPE_HI: begin
        hdr_type[15:8] = b;
        hdr_length     = '0;
        payload_count  = '0;
        check_lo_byte  = '0;
        rx_phase       = PH_LEN0;
      end
      PH_LEN0: begin
        hdr_length = {24'h0, b};
        rx_phase   = PH_LEN1;
      end
      PH_LEN1: begin
        hdr_length[15:8] = b;
        rx_phase         = PH_LEN2;
      end
      PH_LEN2: begin
        hdr_length[23:16] = b;
        rx_phase          = PH_LEN3;
      end
      PH_LEN3: begin
        hdr_length[31:24] = b;
        rx_phase = (hdr_length == 0) ? PH_CHECK_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        payload_count = payload_count + 1;
        if (payload_count >= hdr_length) rx_phase = PH_CHECK_LO;
        push_result(KIND_PAYLOAD, b);
      end
      PH_CHECK_LO: begin
        check_lo_byte = b;
        rx_phase      = PH_CHECK_HI;
      end
      PH_CHECK_HI: begin
        push_result(({b, check_lo_byte} == 16'h0000) ? KIND_ACCEPT : KIND_REJECT, 8'h00);
        rx_phase = PH_SYNC0;
      end
      default: rx_phase = PH_SYNC0;
    endcase
  endtask

  // Drive one byte, with an occasional gap, and wait for its transaction
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 15) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    do @(posedge clk); while (!s_tready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Write sync_value once every expected result has drained
  task automatic write_sync(input logic [7:0] v);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sync_shadow = v;
    @(negedge clk);
    cfg_valid = 1'b0;
    sync_writes++;
  endtask

  task automatic send_header(input logic [7:0] snd, input logic [15:0] typ,
                             input logic [31:0] len);
    send_byte(sync_shadow);
    send_byte(sync_shadow);
    send_byte(snd);
    send_byte(rand_byte());
    send_byte(rand_byte());
    send_byte(typ[7:0]);
    send_byte(typ[15:8]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    send_byte(len[23:16]);
    send_byte(len[31:24]);
  endtask

  task automatic send_frame(input logic [7:0] snd, input logic [15:0] typ,
                            input logic [31:0] len, input logic [15:0] chk);
    int i;
    send_header(snd, typ, len);
    for (i = 0; i < int'(len); i++) send_byte(rand_byte());
    send_byte(chk[7:0]);
    send_byte(chk[15:8]);
    frames_sent++;
  endtask

  // Feed bytes that steer the deframer back to hunting with a short length
  task automatic resync();
    while (rx_phase != PH_SYNC0) begin
      case (rx_phase)
        PH_SYNC1:                   send_byte(sync_shadow ^ 8'h01);
        PH_LEN0:                    send_byte(8'($urandom_range(0, 6)));
        PH_LEN1, PH_LEN2, PH_LEN3:  send_byte(8'h00);
        default:                    send_byte(rand_byte());
      endcase
    end
  endtask

  // Random bytes while hunting; stop before noise could set a length
  task automatic send_noise(input int n);
    int i;
    for (i = 0; i < n && rx_phase < PH_TYPE_LO; i++) begin
      send_byte(($urandom_range(0, 4) == 0) ? sync_shadow : rand_byte());
    end
  endtask

  // Sync pattern cut short: wrong second sync byte or a truncated header
  task automatic send_broken();
    int n;
    send_byte(sync_shadow);
    if ($urandom_range(0, 3) == 0) begin
      send_byte(sync_shadow ^ 8'($urandom_range(1, 255)));
    end else begin
      send_byte(sync_shadow);
      n = $urandom_range(0, 5);
      repeat (n) send_byte(rand_byte());
    end
  endtask

  task automatic test_default_sync();
    send_frame(8'h00, 16'h0000, 32'd0, 16'h0000);
  endtask

  task automatic test_bad_sync_and_extremes();
    send_byte(sync_shadow ^ 8'h80);
    send_byte(sync_shadow);
    send_byte(sync_shadow ^ 8'h01);
    send_header(8'hFF, 16'hFFFF, 32'd1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h01);
    frames_sent++;
  endtask

  task automatic test_random_traffic(input logic [7:0] sync_v, input int budget,
                                     input logic idling);
    int stop_at;
    int r;
    int len;
    write_sync(sync_v);
    idle_on = idling;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        send_frame(rand_byte(), {rand_byte(), rand_byte()}, len,
                   $urandom_range(0, 1) ? 16'h0000 : 16'($urandom_range(0, 65535)));
      end else if (r < 90) begin
        send_noise($urandom_range(1, 6));
        resync();
      end else begin
        send_broken();
        resync();
      end
    end
    idle_on = 1'b1;
  endtask

  // Long payloads: one complete, then a top-range length that must not end early
  task automatic test_long_frames();
    send_frame(rand_byte(), 16'h0100, 32'd256, 16'h0000);
    send_header(8'hA5, 16'hC3C3, 32'hFFFF_FFFF);
    repeat (24) send_byte(rand_byte());
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("time %0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("time %0t: unexpected result, expected none actual kind %0d data 0x%0h",
                 $time, m_tuser, m_tdata);
        mismatch_count++;
      end else begin
        want_result = pending_results.pop_front();
        check_field("kind", 32'(want_result.kind), 32'(m_tuser));
        check_field("payload_byte", 32'(want_result.payload_byte), 32'(m_tdata[7:0]));
        check_field("sender", 32'(want_result.sender), 32'(m_tdata[15:8]));
        check_field("message_type", 32'(want_result.message_type), 32'(m_tdata[31:16]));
        check_field("payload_length", want_result.payload_length, m_tdata[63:32]);
        results_checked++;
      end
    end
  end

  // End the run when no transaction happens for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               stall_cycles, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_sync();
    test_bad_sync_and_extremes();
    test_random_traffic(8'h00, 130, 1'b1);
    test_random_traffic(8'hFF, 130, 1'b0);
    test_random_traffic(8'($urandom_range(1, 254)), 130, 1'b1);
    test_long_frames();

    // Drain outstanding results, then allow the output register to settle
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("sent %0d bytes in %0d frames plus noise, checked %0d results",
             bytes_sent, frames_sent, results_checked);
    $display("sync value written %0d times, including 0x00 and 0xFF", sync_writes);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
